// ===== src/ppi_pkg.sv =====
package ppi_pkg;

    typedef enum logic [1:0] {
        CMD_EMIT  = 2'd0,
        CMD_STEP  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic [30:0]        life_span;
        logic [30:0]        time_step;
        logic signed [31:0] acc_x;
        logic signed [31:0] acc_y;
        logic signed [31:0] acc_z;
    } req_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [16:0]        life_fraction;
        logic [5:0]         rank;
        logic [6:0]         live_total;
        logic               last;
    } rsp_t;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic [30:0]        span;
        logic signed [32:0] rem;
        logic [16:0]        frac;
    } slot_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_CHK,
        ST_VMUL,
        ST_VADD,
        ST_PMUL,
        ST_PADD,
        ST_DIV,
        ST_WB,
        ST_OUT
    } state_t;

    localparam logic signed [48:0] SAT_HI = 49'sd2147483647;
    localparam logic signed [48:0] SAT_LO = -49'sd2147483648;

    function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
        logic signed [31:0] r;
        if (v > SAT_HI)
            r = 32'sh7fffffff;
        else if (v < SAT_LO)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ===== src/ppi_mulq.sv =====
module ppi_mulq
    import ppi_pkg::*;
(
    input  logic               clk,
    input  logic signed [31:0] a,
    input  logic [30:0]        step,
    output logic signed [47:0] prod
);
    logic signed [63:0] full;

    assign full = a * $signed({1'b0, step});

    always_ff @(posedge clk)
    begin
        prod <= full[63:16];
    end
endmodule

// ===== src/ppi_div.sv =====
module ppi_div
    import ppi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [48:0] num,
    input  logic [30:0] den,
    output logic        done,
    output logic [16:0] quo
);
    logic [48:0] rem_reg, rem_next;
    logic [17:0] q_reg, q_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic [49:0] trial;
    logic [48:0] dsh;

    always_comb
    begin
        dsh      = 49'(den) << (6'd17 - cnt_reg);
        trial    = {1'b0, rem_reg} - {1'b0, dsh};
        rem_next = rem_reg;
        q_next   = q_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        done     = 1'b0;
        if (start)
        begin
            rem_next = num;
            q_next   = '0;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (!trial[49] && (den == '0 || (49'(den) << (6'd17 - cnt_reg)) >> (6'd17 - cnt_reg)
                == 49'(den)))
            begin
                rem_next = trial[48:0];
                q_next   = {q_reg[16:0], 1'b1};
            end
            else
                q_next = {q_reg[16:0], 1'b0};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd17)
            begin
                run_next = 1'b0;
                done     = 1'b1;
            end
        end
        quo = (q_next > 18'd65536) ? 17'd65536 : q_next[16:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            run_reg <= 1'b0;
        else
            run_reg <= run_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
    end
endmodule

// ===== src/particle_pool_integrator.sv =====
// Particle pool with Euler integration in Q16.16. An emit request is taken
// while idle and leaves busy low. A readout or a time step holds busy while
// it walks the slots, skipping dead ones. A time step retires a slot whose
// life is spent and advances any other live slot by a read of the slot memory,
// a check, two multiply rounds, a restoring divider for the life fraction,
// then a write back; the divider is skipped for a slot whose new life is spent
// or whose span is zero. Results appear one per strobe and cannot be held off
// by the receiver.
module particle_pool_integrator
    import ppi_pkg::*;
#(
    parameter int POOL_SIZE = 64
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic strobe,
    output rsp_t rsp
);
    localparam int IW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam logic [IW:0] LAST_IDX = (IW + 1)'(POOL_SIZE - 1);

    slot_t mem [POOL_SIZE];
    slot_t rd_reg;
    logic  mem_we;
    slot_t wr_data;
    logic [IW-1:0] addr;
    logic [IW-1:0] wr_addr;

    logic [POOL_SIZE-1:0] alive_reg, alive_next;
    logic [IW-1:0] ring_reg, ring_next;
    logic [6:0]    tally_reg, tally_next;
    logic [IW:0]   idx_reg, idx_next;
    logic [5:0]    rank_reg, rank_next;
    state_t        st_reg, st_next;
    req_t          cur_reg, cur_next;
    slot_t         wk_reg, wk_next;
    logic          strobe_reg, strobe_next;
    rsp_t          rsp_reg, rsp_next;

    logic signed [31:0] ma0, ma1, ma2;
    logic signed [47:0] mp0, mp1, mp2;
    logic        div_start, div_done;
    logic [16:0] div_q;
    logic        found;

    ppi_mulq u_m0 (.clk(clk), .a(ma0), .step(cur_reg.time_step), .prod(mp0));
    ppi_mulq u_m1 (.clk(clk), .a(ma1), .step(cur_reg.time_step), .prod(mp1));
    ppi_mulq u_m2 (.clk(clk), .a(ma2), .step(cur_reg.time_step), .prod(mp2));

    ppi_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .num({wk_reg.rem[31:0], 17'd0} >> 1), .den(wk_reg.span),
        .done(div_done), .quo(div_q)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= wr_data;
        rd_reg <= mem[addr];
    end

    always_comb
    begin
        found = 1'b0;
        for (int i = POOL_SIZE - 1; i >= 0; i--)
        begin
            if (alive_reg[i] && (IW + 1)'(i) > idx_reg)
                found = 1'b1;
        end
    end

    always_comb
    begin
        st_next     = st_reg;
        alive_next  = alive_reg;
        ring_next   = ring_reg;
        tally_next  = tally_reg;
        idx_next    = idx_reg;
        rank_next   = rank_reg;
        cur_next    = cur_reg;
        wk_next     = wk_reg;
        strobe_next = 1'b0;
        rsp_next    = rsp_reg;
        mem_we      = 1'b0;
        wr_data     = wk_reg;
        addr        = idx_reg[IW-1:0];
        wr_addr     = idx_reg[IW-1:0];
        div_start   = 1'b0;
        ma0 = cur_reg.acc_x;
        ma1 = cur_reg.acc_y;
        ma2 = cur_reg.acc_z;
        busy = (st_reg != ST_IDLE);
        unique case (st_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cur_next = req;
                    unique case (cmd_t'(req.cmd))
                        CMD_EMIT:
                        begin
                            wr_addr      = ring_reg;
                            mem_we       = 1'b1;
                            wr_data.px   = req.pos_x;
                            wr_data.py   = req.pos_y;
                            wr_data.pz   = req.pos_z;
                            wr_data.vx   = req.vel_x;
                            wr_data.vy   = req.vel_y;
                            wr_data.vz   = req.vel_z;
                            wr_data.span = req.life_span;
                            wr_data.rem  = $signed({2'b0, req.life_span});
                            wr_data.frac = 17'd65536;
                            if (!alive_reg[ring_reg])
                                tally_next = tally_reg + 7'd1;
                            alive_next[ring_reg] = 1'b1;
                            ring_next = ((IW + 1)'(ring_reg) == LAST_IDX) ? '0
                                : ring_reg + 1'b1;
                        end
                        CMD_STEP, CMD_READ:
                        begin
                            idx_next  = '0;
                            rank_next = '0;
                            st_next   = ST_RD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RD:
            begin
                if (idx_reg > LAST_IDX)
                    st_next = ST_IDLE;
                else if (!alive_reg[idx_reg[IW-1:0]])
                    idx_next = idx_reg + 1'b1;
                else
                    st_next = (cur_reg.cmd == CMD_READ) ? ST_OUT : ST_CHK;
            end
            ST_OUT:
            begin
                strobe_next            = 1'b1;
                rsp_next.out_x         = rd_reg.px;
                rsp_next.out_y         = rd_reg.py;
                rsp_next.out_z         = rd_reg.pz;
                rsp_next.life_fraction = rd_reg.frac;
                rsp_next.rank          = rank_reg;
                rsp_next.live_total    = tally_reg;
                rsp_next.last          = !found;
                rank_next = rank_reg + 6'd1;
                idx_next  = idx_reg + 1'b1;
                st_next   = ST_RD;
            end
            ST_CHK:
            begin
                wk_next = rd_reg;
                if (rd_reg.rem <= 0)
                begin
                    alive_next[idx_reg[IW-1:0]] = 1'b0;
                    if (tally_reg != 0)
                        tally_next = tally_reg - 7'd1;
                    idx_next = idx_reg + 1'b1;
                    st_next  = ST_RD;
                end
                else
                begin
                    wk_next.rem = rd_reg.rem - $signed({2'b0, cur_reg.time_step});
                    st_next = ST_VMUL;
                end
            end
            ST_VMUL:
                st_next = ST_VADD;
            ST_VADD:
            begin
                wk_next.vx = sat32(49'($signed(wk_reg.vx)) + 49'(mp0));
                wk_next.vy = sat32(49'($signed(wk_reg.vy)) + 49'(mp1));
                wk_next.vz = sat32(49'($signed(wk_reg.vz)) + 49'(mp2));
                st_next = ST_PMUL;
            end
            ST_PMUL:
            begin
                ma0 = wk_reg.vx;
                ma1 = wk_reg.vy;
                ma2 = wk_reg.vz;
                st_next = ST_PADD;
            end
            ST_PADD:
            begin
                wk_next.px = sat32(49'($signed(wk_reg.px)) + 49'(mp0));
                wk_next.py = sat32(49'($signed(wk_reg.py)) + 49'(mp1));
                wk_next.pz = sat32(49'($signed(wk_reg.pz)) + 49'(mp2));
                if (wk_reg.rem <= 0 || wk_reg.span == '0)
                begin
                    wk_next.frac = '0;
                    st_next = ST_WB;
                end
                else
                begin
                    div_start = 1'b1;
                    st_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    wk_next.frac = div_q;
                    st_next = ST_WB;
                end
            end
            ST_WB:
            begin
                mem_we   = 1'b1;
                idx_next = idx_reg + 1'b1;
                st_next  = ST_RD;
            end
            default:
                st_next = ST_IDLE;
        endcase
        if (st_next == ST_RD)
            addr = idx_next[IW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= ST_IDLE;
            alive_reg  <= '0;
            ring_reg   <= '0;
            tally_reg  <= '0;
            strobe_reg <= 1'b0;
            idx_reg    <= '0;
            rank_reg   <= '0;
        end
        else
        begin
            st_reg     <= st_next;
            alive_reg  <= alive_next;
            ring_reg   <= ring_next;
            tally_reg  <= tally_next;
            strobe_reg <= strobe_next;
            idx_reg    <= idx_next;
            rank_reg   <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        wk_reg  <= wk_next;
        rsp_reg <= rsp_next;
    end

    assign strobe = strobe_reg;
    assign rsp    = rsp_reg;

    a_tally: assert property (@(posedge clk) disable iff (!rst_n)
        tally_reg == 7'($countones(alive_reg)))
        else $error("tally mismatch");
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_next |-> busy)
        else $error("strobe while idle");
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && rsp.last) |-> !strobe_reg || st_reg != ST_OUT)
        else $error("result after last");
endmodule

// ===== tb/sv/particle_pool_integrator_tb.sv =====
module particle_pool_integrator_tb;
    import ppi_pkg::*;

    localparam int POOL = 64;
    localparam int STALL_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 450;

    typedef struct {
        req_t r;
        bit   fixed;
        rsp_t want;
    } row_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic strobe;
    rsp_t rsp;

    particle_pool_integrator #(.POOL_SIZE(POOL)) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req(req),
        .strobe(strobe),
        .rsp(rsp)
    );

    // particle state mirror
    bit     live[POOL];
    longint px[POOL], py[POOL], pz[POOL];
    longint vx[POOL], vy[POOL], vz[POOL];
    longint span_of[POOL], rem_of[POOL], frac_of[POOL];
    int     next_slot;
    int     live_count;

    rsp_t   pending_particles[$];
    int     errors;
    int     idle_cycles;
    row_t   rows[$];

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint scale_q(longint a, longint dt);
        longint p;
        p = a * dt;
        return p >>> 16;
    endfunction

    function automatic longint fraction(longint rem, longint span);
        longint f;
        if (rem <= 0 || span == 0)
            return 0;
        f = (rem << 16) / span;
        return (f > 65536) ? 65536 : f;
    endfunction

    function automatic req_t make_req(cmd_t c, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                      logic [31:0] u, logic [31:0] v, logic [31:0] w,
                                      logic [30:0] sp, logic [30:0] dt,
                                      logic [31:0] ax, logic [31:0] ay, logic [31:0] az);
        req_t r;
        r.cmd = c;
        r.pos_x = x;
        r.pos_y = y;
        r.pos_z = z;
        r.vel_x = u;
        r.vel_y = v;
        r.vel_z = w;
        r.life_span = sp;
        r.time_step = dt;
        r.acc_x = ax;
        r.acc_y = ay;
        r.acc_z = az;
        return r;
    endfunction

    function automatic void add_row(req_t r, bit fixed, rsp_t want);
        row_t row;
        row.r = r;
        row.fixed = fixed;
        row.want = want;
        rows.insert(rows.size(), row);
    endfunction

    task automatic integrate_request(req_t r);
        longint dt;
        int     n;
        rsp_t   e;
        case (r.cmd)
            CMD_EMIT:
            begin
                if (!live[next_slot])
                    live_count++;
                live[next_slot] = 1'b1;
                px[next_slot] = r.pos_x;
                py[next_slot] = r.pos_y;
                pz[next_slot] = r.pos_z;
                vx[next_slot] = r.vel_x;
                vy[next_slot] = r.vel_y;
                vz[next_slot] = r.vel_z;
                span_of[next_slot] = r.life_span;
                rem_of[next_slot] = r.life_span;
                frac_of[next_slot] = 65536;
                next_slot = (next_slot + 1) % POOL;
            end
            CMD_STEP:
            begin
                dt = r.time_step;
                for (int i = 0; i < POOL; i++)
                begin
                    if (!live[i])
                        continue;
                    if (rem_of[i] <= 0)
                    begin
                        live[i] = 1'b0;
                        if (live_count > 0)
                            live_count--;
                        continue;
                    end
                    rem_of[i] -= dt;
                    frac_of[i] = fraction(rem_of[i], span_of[i]);
                    vx[i] = clip32(vx[i] + scale_q(r.acc_x, dt));
                    vy[i] = clip32(vy[i] + scale_q(r.acc_y, dt));
                    vz[i] = clip32(vz[i] + scale_q(r.acc_z, dt));
                    px[i] = clip32(px[i] + scale_q(vx[i], dt));
                    py[i] = clip32(py[i] + scale_q(vy[i], dt));
                    pz[i] = clip32(pz[i] + scale_q(vz[i], dt));
                end
            end
            CMD_READ:
            begin
                n = 0;
                for (int i = 0; i < POOL; i++)
                begin
                    if (!live[i])
                        continue;
                    e.out_x = px[i][31:0];
                    e.out_y = py[i][31:0];
                    e.out_z = pz[i][31:0];
                    e.life_fraction = frac_of[i][16:0];
                    e.rank = n[5:0];
                    e.live_total = live_count[6:0];
                    e.last = 1'b0;
                    pending_particles.insert(pending_particles.size(), e);
                    n++;
                end
                if (n > 0)
                    pending_particles[pending_particles.size() - 1].last = 1'b1;
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk)
    begin
        rsp_t e;
        if (rst_n && strobe)
        begin
            if (pending_particles.size() == 0)
            begin
                $error("unexpected result x=%h y=%h z=%h", rsp.out_x, rsp.out_y, rsp.out_z);
                errors++;
            end
            else
            begin
                e = pending_particles.pop_front();
                if (rsp.out_x !== e.out_x)
                begin
                    $error("out_x expected %h actual %h", e.out_x, rsp.out_x);
                    errors++;
                end
                if (rsp.out_y !== e.out_y)
                begin
                    $error("out_y expected %h actual %h", e.out_y, rsp.out_y);
                    errors++;
                end
                if (rsp.out_z !== e.out_z)
                begin
                    $error("out_z expected %h actual %h", e.out_z, rsp.out_z);
                    errors++;
                end
                if (rsp.life_fraction !== e.life_fraction)
                begin
                    $error("life_fraction expected %h actual %h",
                           e.life_fraction, rsp.life_fraction);
                    errors++;
                end
                if (rsp.rank !== e.rank)
                begin
                    $error("rank expected %0d actual %0d", e.rank, rsp.rank);
                    errors++;
                end
                if (rsp.live_total !== e.live_total)
                begin
                    $error("live_total expected %0d actual %0d", e.live_total, rsp.live_total);
                    errors++;
                end
                if (rsp.last !== e.last)
                begin
                    $error("last expected %0b actual %0b", e.last, rsp.last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || strobe || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send(req_t r, bit fixed, rsp_t want, int gap);
        int n0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req <= r;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        n0 = pending_particles.size();
        integrate_request(r);
        if (fixed)
            pending_particles[n0] = want;
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        int k;
        k = $urandom_range(0, 3);
        if (k == 0)
            return $urandom;
        return $urandom_range(0, 32'h40000) - 32'h20000;
    endfunction

    function automatic logic [30:0] rand_span();
        if ($urandom_range(0, 7) == 0)
            return 31'($urandom);
        return 31'($urandom_range(0, 32'h80000));
    endfunction

    function automatic logic [30:0] rand_dt();
        if ($urandom_range(0, 15) == 0)
            return 31'($urandom);
        return 31'($urandom_range(0, 32'h20000));
    endfunction

    initial
    begin
        rsp_t  none;
        rsp_t  w;
        req_t  r;
        cmd_t  c;
        int    k;
        bit    burst;

        errors = 0;
        idle_cycles = 0;
        next_slot = 0;
        live_count = 0;
        none = '0;
        start = 1'b0;
        req = '0;
        rst_n = 1'b0;
        for (int i = 0; i < POOL; i++)
            live[i] = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        w.out_x = 32'h7fffffff;
        w.out_y = 32'h80000000;
        w.out_z = 32'h0;
        w.life_fraction = 17'd65536;
        w.rank = 6'd0;
        w.live_total = 7'd1;
        w.last = 1'b1;

        add_row(make_req(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
        add_row(make_req(CMD_NONE, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1), 0, none);
        add_row(make_req(CMD_EMIT, 32'h7fffffff, 32'h80000000, 0, 32'h7fffffff,
                         32'h80000000, 0, 31'h7fffffff, 0, 0, 0, 0), 0, none);
        add_row(make_req(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, w);
        add_row(make_req(CMD_STEP, 0, 0, 0, 0, 0, 0, 0, 31'h10000, 32'h7fffffff,
                         32'h80000000, 0), 0, none);
        add_row(make_req(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
        add_row(make_req(CMD_EMIT, 32'hffffffff, 1, 32'h80000000, 32'h80000000,
                         32'h7fffffff, 32'hffff0000, 0, 0, 0, 0, 0), 0, none);
        add_row(make_req(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
        add_row(make_req(CMD_STEP, 0, 0, 0, 0, 0, 0, 0, 31'h7fffffff, 32'h80000000,
                         32'h7fffffff, 32'h7fffffff), 0, none);
        add_row(make_req(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
        add_row(make_req(CMD_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
        add_row(make_req(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
        add_row(make_req(CMD_EMIT, 32'h10000, 32'hfffe0000, 32'h8000, 32'h18000,
                         32'hffff8000, 0, 31'h30000, 0, 0, 0, 0), 0, none);
        add_row(make_req(CMD_STEP, 0, 0, 0, 0, 0, 0, 0, 31'h10000, 32'h8000,
                         32'hfff00000, 32'h1), 0, none);
        add_row(make_req(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
        add_row(make_req(CMD_STEP, 0, 0, 0, 0, 0, 0, 0, 31'h28000, 32'hffffffff,
                         0, 0), 0, none);
        add_row(make_req(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
        add_row(make_req(CMD_STEP, 0, 0, 0, 0, 0, 0, 0, 31'h100, 0, 0, 0), 0, none);
        add_row(make_req(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);

        foreach (rows[i])
            send(rows[i].r, rows[i].fixed, rows[i].want, $urandom_range(0, 5));

        burst = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 50 == 0)
                burst = ($urandom_range(0, 2) == 0);
            k = $urandom_range(0, 99);
            if (k < 50)
                c = CMD_EMIT;
            else if (k < 78)
                c = CMD_STEP;
            else if (k < 95)
                c = CMD_READ;
            else
                c = CMD_NONE;
            r = make_req(c, rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                         rand_word(), rand_span(), rand_dt(), rand_word(), rand_word(),
                         rand_word());
            send(r, 1'b0, none, burst ? 0 : $urandom_range(0, 5));
        end
        start <= 1'b0;

        while (pending_particles.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        if (errors == 0 && pending_particles.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
